/* rtl/key_set_table_macros.svh */
// Assertion macros shared by the key set table RTL.
`ifndef KEY_SET_TABLE_MACROS_SVH
`define KEY_SET_TABLE_MACROS_SVH

// Check a property on every clock, ignored while reset is held.
`define KST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kst_pkg.sv */
// Package with sizes, codes and helpers for the key set table.
package kst_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_W    = 11;

  // Request codes
  localparam logic [1:0] REQ_FIND   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // Fit a count to the result width (zero-extend or drop high bits).
  function automatic logic [OUT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, v};
    return ext[OUT_W-1:0];
  endfunction

  // Fit an entry index to the result width.
  function automatic logic [OUT_W-1:0] idx_to_out(input logic [IDX_W-1:0] v);
    logic [IDX_W+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, v};
    return ext[OUT_W-1:0];
  endfunction

endpackage

/* rtl/kst_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/key_set_table.sv */
// Top level of the key set table: sequencer around one entry-wide key RAM.
//
// A dense set of 256-bit keys with a fill count. A request is taken when start
// is high and busy is low; exactly one result follows, shown for one cycle
// with out_strobe, and the receiver cannot stall it. An add, or an unused
// request code, does not raise busy, so such requests may follow each other
// every cycle; the result appears the cycle after the transfer. Find and
// remove scan the entry RAM from index 0, one entry per cycle through its
// one read port: a find that hits ends at the first matching entry, a miss
// after the last entry is compared (an empty table is answered like an add,
// without raising busy). A remove that hits then reads the last entry and
// writes it over the freed slot. No clearing pass is needed after reset.
`include "key_set_table_macros.svh"

module key_set_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic [63:0]              in_key_word0,
  input  logic [63:0]              in_key_word1,
  input  logic [63:0]              in_key_word2,
  input  logic [63:0]              in_key_word3,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic [kst_pkg::OUT_W-1:0] out_result_value,
  output logic [kst_pkg::OUT_W-1:0] out_fill_count
);

  import kst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_MOVE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             vld_r, vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             strobe_r, strobe_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [OUT_W-1:0] value_r, value_nxt;
  logic [OUT_W-1:0] fill_r, fill_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_data;

  logic [KEY_W-1:0] key_in;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] last_idx;
  logic             hit;

  assign key_in    = {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
  assign count_inc = count_r + CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);
  assign last_idx  = count_dec[IDX_W-1:0];
  assign hit       = vld_r && (rd_data == key_r);
  assign busy      = (state_r != S_IDLE);

  // Entry RAM: one 256-bit key per word
  kst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequence requests: append, scan, move last entry
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    issue_nxt   = issue_r;
    vld_nxt     = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    hit_idx_nxt = hit_idx_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    value_nxt   = value_r;
    fill_nxt    = fill_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[IDX_W-1:0];
    wr_data     = key_in;
    rd_en       = 1'b0;
    rd_addr     = issue_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_req_type;
          key_nxt   = key_in;
          issue_nxt = '0;
          unique case (in_req_type)
            REQ_ADD: begin
              strobe_nxt = 1'b1;
              if (count_r < CNT_W'(CAPACITY)) begin
                wr_en      = 1'b1;
                count_nxt  = count_inc;
                status_nxt = STAT_OK;
                value_nxt  = cnt_to_out(count_inc);
                fill_nxt   = cnt_to_out(count_inc);
              end else begin
                status_nxt = STAT_FULL;
                value_nxt  = '0;
                fill_nxt   = cnt_to_out(count_r);
              end
            end
            REQ_FIND, REQ_REMOVE: begin
              if (count_r == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = STAT_NOT_FOUND;
                value_nxt  = '0;
                fill_nxt   = cnt_to_out(count_r);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
              status_nxt = STAT_NOT_FOUND;
              value_nxt  = '0;
              fill_nxt   = cnt_to_out(count_r);
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (hit) begin
          if (op_r == REQ_FIND) begin
            strobe_nxt = 1'b1;
            status_nxt = STAT_OK;
            value_nxt  = idx_to_out(cmp_idx_r);
            fill_nxt   = cnt_to_out(count_r);
            state_nxt  = S_IDLE;
          end else begin
            hit_idx_nxt = cmp_idx_r;
            state_nxt   = S_LAST;
          end
        end else if (vld_r && (cmp_idx_r == last_idx)) begin
          strobe_nxt = 1'b1;
          status_nxt = STAT_NOT_FOUND;
          value_nxt  = '0;
          fill_nxt   = cnt_to_out(count_r);
          state_nxt  = S_IDLE;
        end else if (issue_r < count_r) begin
          rd_en       = 1'b1;
          vld_nxt     = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end
      end
      S_LAST: begin
        rd_en     = 1'b1;
        rd_addr   = last_idx;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        wr_en      = 1'b1;
        wr_addr    = hit_idx_r;
        wr_data    = rd_data;
        count_nxt  = count_dec;
        strobe_nxt = 1'b1;
        status_nxt = STAT_OK;
        value_nxt  = idx_to_out(hit_idx_r);
        fill_nxt   = cnt_to_out(count_dec);
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      vld_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      vld_r    <= vld_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    status_r  <= status_nxt;
    value_r   <= value_nxt;
    fill_r    <= fill_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_result_value = value_r;
  assign out_fill_count   = fill_r;

  // Checks
  `KST_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "fill count above capacity")
  `KST_ASSERT_NEXT(a_add_grows, start && !busy && (in_req_type == REQ_ADD) && (count_r < CNT_W'(CAPACITY)), count_r == $past(count_inc) && out_strobe, "add with room did not append")
  `KST_ASSERT(a_write_phase, !wr_en || (state_r == S_IDLE) || (state_r == S_MOVE), "RAM write during scan")
  `KST_ASSERT(a_scan_valid, !vld_r || (state_r == S_SCAN), "compare pending outside scan")
  `KST_ASSERT_NEXT(a_move_done, state_r == S_MOVE, out_strobe && (count_r == $past(count_dec)), "remove did not shrink table")

endmodule
